@@ hw/rtl/ppsu_pkg.sv @@
package ppsu_pkg;

  // Palette depth and the address width that follows from it.
  localparam int unsigned PALETTE_ENTRIES = 256;
  localparam int unsigned PAL_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef logic [23:0] rgb_t;

  typedef enum logic {
    REQ_PAL_WRITE = 1'b0,
    REQ_DATA      = 1'b1
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BPP   = 2'd0,
    CFG_WIDTH = 2'd1,
    CFG_ALIGN = 2'd2
  } cfg_reg_e;

  typedef struct packed {
    logic              en;
    logic [PAL_AW-1:0] addr;
    rgb_t              data;
  } pal_wr_t;

  // Take the leading pixel index from the top bits of a packed byte.
  function automatic logic [7:0] pixel_index(logic [7:0] b, logic [1:0] bpp_log2);
    logic [7:0] idx;
    case (bpp_log2)
      2'd0:    idx = {7'd0, b[7]};
      2'd1:    idx = {6'd0, b[7:6]};
      2'd2:    idx = {4'd0, b[7:4]};
      default: idx = b;
    endcase
    return idx;
  endfunction

  // Pixels per byte, minus one.
  function automatic logic [2:0] pixels_per_byte_m1(logic [1:0] bpp_log2);
    logic [2:0] n;
    case (bpp_log2)
      2'd0:    n = 3'd7;
      2'd1:    n = 3'd3;
      2'd2:    n = 3'd1;
      default: n = 3'd0;
    endcase
    return n;
  endfunction

  function automatic logic index_in_range(logic [7:0] idx);
    return ({1'b0, idx} < 9'(PALETTE_ENTRIES));
  endfunction

endpackage

@@ hw/rtl/ppsu_if.sv @@
interface ppsu_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] data_byte;
  logic [7:0] entry_index;
  logic [7:0] entry_red;
  logic [7:0] entry_green;
  logic [7:0] entry_blue;

  modport source (
    output valid, req_type, data_byte, entry_index, entry_red, entry_green, entry_blue,
    input  ready
  );
  modport sink (
    input  valid, req_type, data_byte, entry_index, entry_red, entry_green, entry_blue,
    output ready
  );
endinterface

interface ppsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       row_end;
  logic       last_of_run;

  modport source (
    output valid, red, green, blue, row_end, last_of_run,
    input  ready
  );
  modport sink (
    input  valid, red, green, blue, row_end, last_of_run,
    output ready
  );
endinterface

@@ hw/rtl/ppsu_palette_ram.sv @@
module ppsu_palette_ram (
  input  logic                          clk_i,
  input  ppsu_pkg::pal_wr_t             wr_i,
  input  logic                          rd_en_i,
  input  logic [ppsu_pkg::PAL_AW-1:0]   rd_addr_i,
  output ppsu_pkg::rgb_t                rd_data_o
);
  import ppsu_pkg::*;

  rgb_t mem_q [PALETTE_ENTRIES];
  rgb_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    // Hold the read data unless a new read is issued.
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ hw/rtl/packed_palette_pixel_stream_unpacker.sv @@
// Packed indexed-color unpacker with palette lookup. Items on item_i are either palette
// writes (req_type 0), which load one 24-bit RGB entry, or image data bytes (req_type 1)
// holding 1, 2, 4 or 8 bit pixel indexes, first pixel in the high bits. A data byte
// yields 8, 4, 2 or 1 pixels on pixel_o, one per cycle while the output is not stalled,
// fewer when the row ends inside the byte; the rate is set by the single read port
// of the palette RAM, which is read once per pixel. The next item is taken in the
// cycle the current one finishes, so a stream of 8-bit data bytes runs at one pixel
// per cycle while the output is not stalled. At a row end the rest of the byte is
// dropped, and the following padding bytes (to fill the row to a multiple of 1, 2, 4
// or 8 bytes) are swallowed with no output. Palette lookup is registered, and the
// read data register doubles as the output register. Reading a palette entry that
// was never written returns arbitrary color. Write the configuration only while no item is in flight.
module packed_palette_pixel_stream_unpacker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  ppsu_in_if.sink                           item_i,
  ppsu_out_if.source                        pixel_o,
  input  logic                              cfg_we_i,
  input  logic [ppsu_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ppsu_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import ppsu_pkg::*;

  // Configuration registers.
  logic [1:0]  bpp_q;
  logic [15:0] width_q;
  logic [1:0]  align_q;

  // Item under work.
  logic        hold_valid_q, hold_valid_d;
  logic        hold_first_q, hold_first_d;
  req_e        hold_type_q, hold_type_d;
  logic [7:0]  hold_byte_q, hold_byte_d;
  logic [2:0]  hold_rem_q, hold_rem_d;
  logic [7:0]  hold_idx_q, hold_idx_d;
  rgb_t        hold_rgb_q, hold_rgb_d;

  // Row state.
  logic [15:0] col_q, col_d;
  logic [2:0]  pad_q, pad_d;
  logic [2:0]  rbc_q, rbc_d;

  // Output stage; color comes from the RAM read register.
  logic        out_valid_q, out_valid_d;
  logic        out_row_end_q, out_row_end_d;
  logic        out_last_q, out_last_d;
  logic        out_zero_q, out_zero_d;

  logic        adv, pal_step, is_data, pad_drop, pix_step, pix_end, pix_last, pix_ok;
  logic        hold_done, in_ready, in_acc;
  logic [2:0]  rem, rbc_inc, align_mask;
  logic [16:0] col_inc;
  logic [7:0]  pix_idx;
  pal_wr_t     pal_wr;
  rgb_t        rd_data;

  // Output register is free or drains this cycle.
  assign adv      = !out_valid_q || pixel_o.ready;
  assign pal_step = hold_valid_q && (hold_type_q == REQ_PAL_WRITE);
  assign is_data  = hold_valid_q && (hold_type_q == REQ_DATA);
  // Drop a whole byte while padding is owed.
  assign pad_drop = is_data && hold_first_q && (pad_q != 3'd0);
  assign pix_step = is_data && !pad_drop && adv;

  assign rem        = hold_first_q ? pixels_per_byte_m1(bpp_q) : hold_rem_q;
  assign rbc_inc    = hold_first_q ? rbc_q + 3'd1 : rbc_q;
  assign col_inc    = {1'b0, col_q} + 17'd1;
  assign pix_end    = (col_inc >= {1'b0, width_q});
  assign pix_last   = pix_end || (rem == 3'd0);
  assign align_mask = 3'((4'd1 << align_q) - 4'd1);
  assign pix_idx    = pixel_index(hold_byte_q, bpp_q);
  assign pix_ok     = index_in_range(pix_idx);

  assign hold_done = pal_step || pad_drop || (pix_step && pix_last);
  assign in_ready  = !hold_valid_q || hold_done;
  assign in_acc    = item_i.valid && in_ready;
  assign item_i.ready = in_ready;

  assign pal_wr.en   = pal_step && index_in_range(hold_idx_q);
  assign pal_wr.addr = hold_idx_q[PAL_AW-1:0];
  assign pal_wr.data = hold_rgb_q;

  ppsu_palette_ram u_palette (
    .clk_i     (clk_i),
    .wr_i      (pal_wr),
    .rd_en_i   (pix_step),
    .rd_addr_i (pix_idx[PAL_AW-1:0]),
    .rd_data_o (rd_data)
  );

  // Row counters: advance per pixel, clear at row end, drop padding.
  always_comb begin
    col_d = col_q;
    pad_d = pad_q;
    rbc_d = rbc_q;
    if (pad_drop) begin
      pad_d = pad_q - 3'd1;
    end else if (pix_step) begin
      if (pix_end) begin
        col_d = '0;
        pad_d = (3'd0 - rbc_inc) & align_mask;
        rbc_d = '0;
      end else begin
        col_d = col_inc[15:0];
        rbc_d = rbc_inc;
      end
    end
  end

  // Hold stage: load a new item, retire a finished one, or shift out one pixel of the current byte.
  always_comb begin
    hold_valid_d = hold_valid_q;
    hold_first_d = hold_first_q;
    hold_type_d  = hold_type_q;
    hold_byte_d  = hold_byte_q;
    hold_rem_d   = hold_rem_q;
    hold_idx_d   = hold_idx_q;
    hold_rgb_d   = hold_rgb_q;
    if (in_acc) begin
      hold_valid_d = 1'b1;
      hold_first_d = 1'b1;
      hold_type_d  = req_e'(item_i.req_type);
      hold_byte_d  = item_i.data_byte;
      hold_idx_d   = item_i.entry_index;
      hold_rgb_d   = {item_i.entry_red, item_i.entry_green, item_i.entry_blue};
    end else if (hold_done) begin
      hold_valid_d = 1'b0;
    end else if (pix_step) begin
      hold_first_d = 1'b0;
      hold_byte_d  = hold_byte_q << (4'd1 << bpp_q);
      hold_rem_d   = rem - 3'd1;
    end
  end

  // Output stage: fill on a pixel, empty when taken.
  always_comb begin
    out_valid_d   = out_valid_q;
    out_row_end_d = out_row_end_q;
    out_last_d    = out_last_q;
    out_zero_d    = out_zero_q;
    if (pix_step) begin
      out_valid_d   = 1'b1;
      out_row_end_d = pix_end;
      out_last_d    = pix_last;
      out_zero_d    = !pix_ok;
    end else if (pixel_o.ready) begin
      out_valid_d   = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bpp_q        <= 2'd0;
      width_q      <= 16'd1;
      align_q      <= 2'd2;
      hold_valid_q <= 1'b0;
      hold_first_q <= 1'b0;
      col_q        <= '0;
      pad_q        <= '0;
      rbc_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_BPP:   bpp_q   <= cfg_data_i[1:0];
          CFG_WIDTH: width_q <= cfg_data_i[15:0];
          CFG_ALIGN: align_q <= cfg_data_i[1:0];
          default:   ;
        endcase
      end
      hold_valid_q <= hold_valid_d;
      hold_first_q <= hold_first_d;
      col_q        <= col_d;
      pad_q        <= pad_d;
      rbc_q        <= rbc_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    hold_type_q   <= hold_type_d;
    hold_byte_q   <= hold_byte_d;
    hold_rem_q    <= hold_rem_d;
    hold_idx_q    <= hold_idx_d;
    hold_rgb_q    <= hold_rgb_d;
    out_row_end_q <= out_row_end_d;
    out_last_q    <= out_last_d;
    out_zero_q    <= out_zero_d;
  end

  assign pixel_o.valid       = out_valid_q;
  assign pixel_o.red         = out_zero_q ? 8'd0 : rd_data[23:16];
  assign pixel_o.green       = out_zero_q ? 8'd0 : rd_data[15:8];
  assign pixel_o.blue        = out_zero_q ? 8'd0 : rd_data[7:0];
  assign pixel_o.row_end     = out_row_end_q;
  assign pixel_o.last_of_run = out_last_q;

  // A stalled pixel must not see its color overwritten by a new read.
  a_stall_holds_color: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !pixel_o.ready |=> $stable(rd_data))
    else $error("palette read data changed under a stalled pixel");

  // Padding is only owed at the start of a row.
  a_pad_at_row_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pad_q != 3'd0 |-> col_q == 16'd0)
    else $error("padding pending in the middle of a row");

  // After the last pixel of a byte, the hold stage is empty or holds a fresh item.
  a_byte_retired: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pix_step && pix_last |=> !hold_valid_q || hold_first_q)
    else $error("byte not retired after its last pixel");

  // A row end always closes the run of its byte.
  a_row_end_closes_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_row_end_q |-> out_last_q)
    else $error("row end without last_of_run");

endmodule

@@ bench/tb_top.sv @@
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ppsu_pkg::*;

  // Cycles with no accepted item on either channel before the run is abandoned.
  localparam int unsigned STALL_LIMIT = 3000;
  // Quiet cycles after the last pixel, long enough to swallow trailing padding bytes.
  localparam int unsigned SETTLE_CYCLES = 16;
  // Receiver hold-off used to fill the block and stall its input.
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  // Register index beyond the defined set; a write there must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  typedef struct packed {
    req_e       kind;
    logic [7:0] data_byte;
    logic [7:0] entry_index;
    logic [7:0] entry_red;
    logic [7:0] entry_green;
    logic [7:0] entry_blue;
  } item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_end;
    logic       last_of_run;
  } pixel_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  ppsu_in_if  item_if ();
  ppsu_out_if pix_if ();

  packed_palette_pixel_stream_unpacker dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .item_i     (item_if),
    .pixel_o    (pix_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // Shadow of the block: palette, row position and register copies.
  rgb_t        pal_mem     [PALETTE_ENTRIES];
  bit          pal_written [PALETTE_ENTRIES];
  logic [15:0] col_cnt    = '0;
  logic [2:0]  pad_left   = '0;
  logic [2:0]  row_bytes  = '0;
  logic [1:0]  bpp_log2   = 2'd0;
  logic [15:0] row_width  = 16'd1;
  logic [1:0]  align_log2 = 2'd2;

  // Pixels predicted but not yet seen on the output, oldest first.
  pixel_t pending_pixels[$];

  int unsigned mismatches = 0;
  int unsigned hold_off_req = 0;
  bit          feed_gaps_on = 1'b1;
  bit          drain_gaps_on = 1'b1;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Apply one accepted item to the shadow state and queue the pixels it yields.
  function automatic void unpack_and_lookup(input item_t it);
    int         bpp;
    int         shift;
    int         nxt;
    logic [7:0] mask;
    logic [7:0] idx;
    logic [2:0] amask;
    rgb_t       colour;
    pixel_t     px;
    bit         done;
    if (it.kind == REQ_PAL_WRITE) begin
      if ({1'b0, it.entry_index} < 9'(PALETTE_ENTRIES)) begin
        pal_mem[it.entry_index]     = {it.entry_red, it.entry_green, it.entry_blue};
        pal_written[it.entry_index] = 1'b1;
      end
      return;
    end
    // Drop padding bytes without output.
    if (pad_left != 3'd0) begin
      pad_left = pad_left - 3'd1;
      return;
    end
    bpp       = 1 << bpp_log2;
    mask      = 8'((1 << bpp) - 1);
    amask     = 3'((1 << align_log2) - 1);
    row_bytes = row_bytes + 3'd1;
    shift     = 8;
    done      = 1'b0;
    while (!done && shift >= bpp) begin
      shift  = shift - bpp;
      idx    = (it.data_byte >> shift) & mask;
      colour = ({1'b0, idx} < 9'(PALETTE_ENTRIES)) ? pal_mem[idx] : '0;
      nxt    = int'(col_cnt) + 1;
      px.red         = colour[23:16];
      px.green       = colour[15:8];
      px.blue        = colour[7:0];
      px.row_end     = (nxt >= int'(row_width));
      px.last_of_run = px.row_end || (shift < bpp);
      pending_pixels.push_back(px);
      if (px.row_end) begin
        // End the row: discard the rest of the byte, then pad to the alignment.
        col_cnt   = '0;
        pad_left  = (3'd0 - row_bytes) & amask;
        row_bytes = '0;
        done      = 1'b1;
      end else begin
        col_cnt = 16'(nxt);
      end
    end
  endfunction

  function automatic item_t pal_write_item(input logic [7:0] idx, input rgb_t rgb);
    item_t it;
    it.kind        = REQ_PAL_WRITE;
    it.data_byte   = 8'($urandom());
    it.entry_index = idx;
    it.entry_red   = rgb[23:16];
    it.entry_green = rgb[15:8];
    it.entry_blue  = rgb[7:0];
    return it;
  endfunction

  function automatic item_t data_item(input logic [7:0] b);
    item_t it;
    it.kind        = REQ_DATA;
    it.data_byte   = b;
    it.entry_index = 8'($urandom());
    it.entry_red   = 8'($urandom());
    it.entry_green = 8'($urandom());
    it.entry_blue  = 8'($urandom());
    return it;
  endfunction

  // Offer one item after an optional gap and hold it until accepted.
  // Valid stays high on return so that a following item can go back to back.
  task automatic send_item(input item_t it);
    int gap;
    gap = feed_gaps_on ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_if.valid       <= 1'b1;
    item_if.req_type    <= it.kind;
    item_if.data_byte   <= it.data_byte;
    item_if.entry_index <= it.entry_index;
    item_if.entry_red   <= it.entry_red;
    item_if.entry_green <= it.entry_green;
    item_if.entry_blue  <= it.entry_blue;
    @(posedge clk);
    while (!item_if.ready) @(posedge clk);
    unpack_and_lookup(it);
  endtask

  task automatic send_palette(input logic [7:0] idx, input rgb_t rgb);
    send_item(pal_write_item(idx, rgb));
  endtask

  // Load any palette entry this byte could read before sending the byte itself.
  task automatic send_byte(input logic [7:0] b);
    int         bpp;
    int         shift;
    logic [7:0] mask;
    logic [7:0] idx;
    bpp  = 1 << bpp_log2;
    mask = 8'((1 << bpp) - 1);
    for (shift = 8 - bpp; shift >= 0; shift = shift - bpp) begin
      idx = (b >> shift) & mask;
      if (!pal_written[idx]) send_palette(idx, rgb_t'($urandom()));
    end
    send_item(data_item(b));
  endtask

  // Drop valid, wait for every predicted pixel, then let padding bytes drain.
  task automatic wait_idle();
    item_if.valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (cfg_reg_e'(idx))
      CFG_BPP:   bpp_log2   = val[1:0];
      CFG_WIDTH: row_width  = val;
      CFG_ALIGN: align_log2 = val[1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [1:0] bpp, input logic [15:0] width,
                            input logic [1:0] align);
    write_reg(CFG_BPP, 16'(bpp));
    write_reg(CFG_WIDTH, width);
    write_reg(CFG_ALIGN, 16'(align));
  endtask

  // Reset values: 1 bit per pixel, one-pixel rows, 4-byte alignment.
  // Each byte gives one pixel and three padding bytes follow it.
  task automatic test_reset_defaults();
    send_palette(8'd0, 24'h000000);
    send_palette(8'd1, 24'hFFFFFF);
    send_byte(8'hFF);
    send_byte(8'hA5);
    send_byte(8'h5A);
    send_byte(8'h00);
    send_byte(8'h00);
    wait_idle();
  endtask

  // 8-bit pixels at the index extremes, no padding.
  task automatic test_index_extremes();
    set_config(2'd3, 16'd2, 2'd0);
    send_palette(8'hFF, 24'hFFFFFF);
    send_palette(8'h00, 24'h000000);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    wait_idle();
  endtask

  // Zero width: every pixel closes its row, so each byte that is not padding
  // yields a single pixel.
  task automatic test_zero_width();
    set_config(2'd1, 16'd0, 2'd1);
    send_byte(8'hE4);
    send_byte(8'h1B);
    send_byte(8'h1B);
    wait_idle();
  endtask

  // Fill part of a maximal row, then shrink the width below the column count:
  // the next pixel must end the row and padding to a multiple of eight bytes follows.
  task automatic test_width_lowered();
    set_config(2'd0, 16'hFFFF, 2'd3);
    send_byte(8'hF0);
    send_byte(8'h0F);
    send_byte(8'hAA);
    wait_idle();
    write_reg(CFG_WIDTH, 16'd3);
    send_byte(8'h80);
    send_byte(8'h7F);
    wait_idle();
  endtask

  // A write to an undefined register index leaves the configuration as it was.
  task automatic test_unused_register();
    write_reg(CFG_UNUSED, 16'hFFFF);
    send_byte(8'h3C);
    wait_idle();
  endtask

  // Hold the receiver off while the sender keeps streaming 1-bit bytes back to back.
  task automatic test_output_backpressure();
    feed_gaps_on  = 1'b0;
    drain_gaps_on = 1'b0;
    set_config(2'd0, 16'd40, 2'd0);
    hold_off_req = HOLD_OFF_CYCLES;
    repeat (24) send_byte(8'($urandom()));
    wait_idle();
    feed_gaps_on  = 1'b1;
    drain_gaps_on = 1'b1;
  endtask

  // Random configurations, each followed by a mixed stream of palette writes and bytes.
  task automatic test_random_streams();
    int          pick;
    logic [15:0] width;
    for (int phase = 0; phase < 7; phase++) begin
      pick = $urandom_range(0, 9);
      if (pick == 0)      width = 16'd1;
      else if (pick <= 6) width = 16'($urandom_range(1, 20));
      else if (pick <= 8) width = 16'($urandom_range(21, 200));
      else                width = 16'hFFFF;
      set_config(2'($urandom_range(0, 3)), width, 2'($urandom_range(0, 3)));
      // Run some phases with no feed gaps and others with no drain gaps.
      feed_gaps_on  = (phase % 3) != 0;
      drain_gaps_on = (phase % 3) != 1;
      repeat (13) begin
        if ($urandom_range(0, 4) == 0) begin
          send_palette(8'($urandom()), rgb_t'($urandom()));
        end else begin
          send_byte(8'($urandom()));
        end
      end
      wait_idle();
    end
    feed_gaps_on  = 1'b1;
    drain_gaps_on = 1'b1;
  endtask

  // Stimulus sequence.
  initial begin : main_seq
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_idx              <= '0;
    cfg_data             <= '0;
    item_if.valid        <= 1'b0;
    item_if.req_type     <= REQ_PAL_WRITE;
    item_if.data_byte    <= '0;
    item_if.entry_index  <= '0;
    item_if.entry_red    <= '0;
    item_if.entry_green  <= '0;
    item_if.entry_blue   <= '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_index_extremes();
    test_zero_width();
    test_width_lowered();
    test_unused_register();
    test_output_backpressure();
    test_random_streams();

    wait_idle();
    if (mismatches == 0 && pending_pixels.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Pixel receiver: random stalls per pixel, plus a long hold-off on request.
  initial begin : pixel_drain
    int gap;
    int hold;
    pix_if.ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (hold_off_req != 0) begin
        hold         = hold_off_req;
        hold_off_req = 0;
        pix_if.ready <= 1'b0;
        repeat (hold) @(posedge clk);
      end
      gap = drain_gaps_on ? $urandom_range(0, 17) : 0;
      if (gap > 0) begin
        pix_if.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      pix_if.ready <= 1'b1;
      @(posedge clk);
      while (!pix_if.valid) @(posedge clk);
    end
  end

  // Compare each accepted pixel with the oldest prediction.
  always @(posedge clk) begin
    pixel_t got;
    pixel_t want;
    if (rst_n && pix_if.valid && pix_if.ready) begin
      got.red         = pix_if.red;
      got.green       = pix_if.green;
      got.blue        = pix_if.blue;
      got.row_end     = pix_if.row_end;
      got.last_of_run = pix_if.last_of_run;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected pixel: rgb=%h_%h_%h row_end=%b last=%b",
                   got.red, got.green, got.blue, got.row_end, got.last_of_run);
      end else begin
        want = pending_pixels.pop_front();
        if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
            got.row_end !== want.row_end || got.last_of_run !== want.last_of_run) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("pixel mismatch: exp rgb=%h_%h_%h row_end=%b last=%b",
                     want.red, want.green, want.blue, want.row_end, want.last_of_run);
            $display("                got rgb=%h_%h_%h row_end=%b last=%b",
                     got.red, got.green, got.blue, got.row_end, got.last_of_run);
          end
        end
      end
    end
  end

  // Abandon the run when neither channel moves for too long.
  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if ((item_if.valid && item_if.ready) || (pix_if.valid && pix_if.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

endmodule

@@ filelist.f @@
hw/rtl/ppsu_pkg.sv
hw/rtl/ppsu_if.sv
hw/rtl/ppsu_palette_ram.sv
hw/rtl/packed_palette_pixel_stream_unpacker.sv
bench/tb_top.sv
